// ===== sv/hpr_pkg.sv =====
// Package for the handshake packet receiver: phase and result-kind codes,
// protocol bytes, and the structs passed between the front, queue and back.
// No dependencies.
package hpr_pkg;

  // Protocol bytes
  localparam logic [7:0]  RTS_BYTE      = 8'hAA;
  localparam logic [7:0]  CTS_BYTE      = 8'hBB;
  localparam logic [7:0]  HDR_BYTE      = 8'd42;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  // Command queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_COUNT  = 2'd2,
    PH_PACKET = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_SEND       = 3'd0,
    KIND_PKT        = 3'd1,
    KIND_INCOMPLETE = 3'd2,
    KIND_UNEXPECTED = 3'd3,
    KIND_TIMEOUT    = 3'd4
  } kind_t;

  // Work item from front to back: a single result or a buffered packet
  typedef struct packed {
    logic       pkt;
    logic       bank;
    kind_t      kind;
    logic [7:0] value;
    logic [5:0] idx;
  } cmd_t;

  // Packet buffer write from front
  typedef struct packed {
    logic       we;
    logic       bank;
    logic [5:0] idx;
    logic [7:0] data;
  } buf_wr_t;

  // Buffer bank handed back by the back end
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

// ===== sv/hpr_queue.sv =====
// Short command queue between the front and back of the packet receiver.
// Depends on hpr_pkg for cmd_t and the queue geometry.
module hpr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hpr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output hpr_pkg::cmd_t pop_cmd,
  output logic          not_empty
);

  hpr_pkg::cmd_t                entry_r [hpr_pkg::QUEUE_DEPTH];
  logic [hpr_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [hpr_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [hpr_pkg::QPTR_W:0]     count_r;

  assign full      = (count_r == (hpr_pkg::QPTR_W+1)'(hpr_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/hpr_front.sv =====
// Front end of the packet receiver: takes input beats, runs the handshake
// phases and timers, fills the packet buffer and queues commands for the back.
// Depends on hpr_pkg.
module hpr_front #(
  parameter int PACKET_BYTES = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_byte,
  input  logic              q_full,
  output logic              q_push,
  output hpr_pkg::cmd_t     q_cmd,
  output hpr_pkg::buf_wr_t  buf_wr,
  input  hpr_pkg::bank_rel_t bank_rel
);

  hpr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     timer_r, timer_nxt;
  logic [15:0]     timeout_r;
  logic [7:0]      left_r, left_nxt;
  logic [5:0]      fill_r, fill_nxt;
  logic            bank_r, bank_nxt;
  logic [1:0]      busy_r, busy_nxt;

  logic            accept;
  logic [15:0]     timer_sat;
  logic            expired;
  logic [6:0]      fill_inc;
  logic            complete;
  logic [7:0]      left_dec;

  // Stall while the bank being filled still waits to be emitted
  assign in_ready = !q_full && !((phase_r == hpr_pkg::PH_PACKET) && busy_r[bank_r]);
  assign accept   = in_valid && in_ready;

  assign timer_sat = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;
  assign expired   = (timer_sat >= timeout_r);
  assign fill_inc  = {1'b0, fill_r} + 7'd1;
  assign complete  = (fill_inc == 7'(PACKET_BYTES));
  assign left_dec  = left_r - 8'd1;

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= hpr_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_data;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hpr_pkg::PH_IDLE;
      timer_r <= '0;
      left_r  <= '0;
      fill_r  <= '0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      left_r  <= left_nxt;
      fill_r  <= fill_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // Phase logic, command generation and buffer writes
  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    left_nxt    = left_r;
    fill_nxt    = fill_r;
    bank_nxt    = bank_r;
    busy_nxt    = busy_r;
    q_push      = 1'b0;
    q_cmd       = '0;
    buf_wr      = '0;
    buf_wr.bank = bank_r;
    buf_wr.idx  = fill_r;
    buf_wr.data = in_byte;

    if (bank_rel.valid) begin
      busy_nxt[bank_rel.bank] = 1'b0;
    end

    if (accept) begin
      case (phase_r)
        hpr_pkg::PH_IDLE: begin
          if (!in_cmd) begin
            q_push = 1'b1;
            if (in_byte == hpr_pkg::RTS_BYTE) begin
              q_cmd.kind  = hpr_pkg::KIND_SEND;
              q_cmd.value = hpr_pkg::CTS_BYTE;
              phase_nxt   = hpr_pkg::PH_HEADER;
              timer_nxt   = '0;
            end else begin
              q_cmd.kind  = hpr_pkg::KIND_UNEXPECTED;
              q_cmd.value = in_byte;
            end
          end
        end
        hpr_pkg::PH_HEADER: begin
          if (in_cmd) begin
            timer_nxt = timer_sat;
            if (expired) begin
              q_push     = 1'b1;
              q_cmd.kind = hpr_pkg::KIND_TIMEOUT;
              phase_nxt  = hpr_pkg::PH_IDLE;
            end
          end else if (in_byte == hpr_pkg::HDR_BYTE) begin
            phase_nxt = hpr_pkg::PH_COUNT;
            timer_nxt = '0;
          end
        end
        hpr_pkg::PH_COUNT: begin
          if (in_cmd) begin
            timer_nxt = timer_sat;
            if (expired) begin
              phase_nxt = hpr_pkg::PH_IDLE;
            end
          end else begin
            left_nxt  = in_byte;
            fill_nxt  = '0;
            timer_nxt = '0;
            phase_nxt = (in_byte == 8'd0) ? hpr_pkg::PH_IDLE : hpr_pkg::PH_PACKET;
          end
        end
        hpr_pkg::PH_PACKET: begin
          if (in_cmd) begin
            timer_nxt = timer_sat;
            if (expired) begin
              // Drop the partial packet and report how far it got
              q_push     = 1'b1;
              q_cmd.kind = hpr_pkg::KIND_INCOMPLETE;
              q_cmd.idx  = fill_r;
              fill_nxt   = '0;
              timer_nxt  = '0;
              left_nxt   = left_dec;
              if (left_dec == 8'd0) begin
                phase_nxt = hpr_pkg::PH_IDLE;
              end
            end
          end else begin
            buf_wr.we = 1'b1;
            timer_nxt = '0;
            fill_nxt  = fill_inc[5:0];
            if (complete) begin
              // Hand the full bank to the back and switch banks
              q_push           = 1'b1;
              q_cmd.pkt        = 1'b1;
              q_cmd.bank       = bank_r;
              q_cmd.kind       = hpr_pkg::KIND_PKT;
              busy_nxt[bank_r] = 1'b1;
              bank_nxt         = !bank_r;
              fill_nxt         = '0;
              left_nxt         = left_dec;
              if (left_dec == 8'd0) begin
                phase_nxt = hpr_pkg::PH_IDLE;
              end
            end
          end
        end
        default: begin
          phase_nxt = hpr_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/hpr_back.sv =====
// Back end of the packet receiver: owns the two-bank packet buffer, drains the
// command queue and drives the result stream through a read stage and an
// output register. Depends on hpr_pkg.
module hpr_back #(
  parameter int PACKET_BYTES = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hpr_pkg::buf_wr_t   buf_wr,
  output hpr_pkg::bank_rel_t bank_rel,
  input  logic               q_valid,
  input  hpr_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output hpr_pkg::kind_t     out_kind,
  output logic [7:0]         out_value,
  output logic [5:0]         out_idx,
  output logic               out_last
);

  localparam int IW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int AW = IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(PACKET_BYTES - 1);

  logic [7:0] mem [2**AW];

  // Emission sequencer
  logic          emit_r;
  logic          emit_bank_r;
  logic [IW-1:0] emit_idx_r;

  // Read stage
  logic           s1_valid_r;
  logic           s1_mem_r;
  hpr_pkg::kind_t s1_kind_r;
  logic [7:0]     s1_value_r;
  logic [5:0]     s1_idx_r;
  logic           s1_last_r;
  logic [7:0]     rd_data_r;

  // Output register
  logic           out_valid_r;
  hpr_pkg::kind_t out_kind_r;
  logic [7:0]     out_value_r;
  logic [5:0]     out_idx_r;
  logic           out_last_r;

  logic          s2_free;
  logic          s1_open;
  logic          issue_mem;
  logic          issue_one;
  logic          rd_bank;
  logic [IW-1:0] rd_idx;
  logic          rd_last;

  assign s2_free   = !out_valid_r || out_ready;
  assign s1_open   = !s1_valid_r || s2_free;
  assign q_pop     = s1_open && !emit_r && q_valid;
  assign issue_mem = s1_open && (emit_r || (q_valid && q_cmd.pkt));
  assign issue_one = q_pop && !q_cmd.pkt;
  assign rd_bank   = emit_r ? emit_bank_r : q_cmd.bank;
  assign rd_idx    = emit_r ? emit_idx_r : '0;
  assign rd_last   = (rd_idx == LAST_IDX);

  // Free the bank once its last byte has been read out
  assign bank_rel.valid = issue_mem && rd_last;
  assign bank_rel.bank  = rd_bank;

  // Buffer write port
  always_ff @(posedge clk) begin
    if (buf_wr.we) begin
      mem[{buf_wr.bank, buf_wr.idx[IW-1:0]}] <= buf_wr.data;
    end
  end

  // Buffer read port, registered
  always_ff @(posedge clk) begin
    if (issue_mem) begin
      rd_data_r <= mem[{rd_bank, rd_idx}];
    end
  end

  // Control: sequencer, stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r      <= 1'b0;
      emit_bank_r <= 1'b0;
      emit_idx_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue_mem) begin
        emit_r      <= !rd_last;
        emit_bank_r <= rd_bank;
        emit_idx_r  <= rd_idx + 1'b1;
      end
      if (s1_open) begin
        s1_valid_r <= issue_mem || issue_one;
      end
      if (s2_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (issue_mem) begin
      s1_mem_r   <= 1'b1;
      s1_kind_r  <= hpr_pkg::KIND_PKT;
      s1_value_r <= '0;
      s1_idx_r   <= 6'(rd_idx);
      s1_last_r  <= rd_last;
    end else if (issue_one) begin
      s1_mem_r   <= 1'b0;
      s1_kind_r  <= q_cmd.kind;
      s1_value_r <= q_cmd.value;
      s1_idx_r   <= q_cmd.idx;
      s1_last_r  <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r) begin
      out_kind_r  <= s1_kind_r;
      out_value_r <= s1_mem_r ? rd_data_r : s1_value_r;
      out_idx_r   <= s1_idx_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_idx   = out_idx_r;
  assign out_last  = out_last_r;

endmodule

// ===== sv/handshake_packet_receiver_unit.sv =====
// Top level of the handshake packet receiver: front end, command queue and
// back end with the packet buffer. Depends on hpr_pkg, hpr_front, hpr_queue, hpr_back.
//
//  channel | direction | tdata                         | tuser      | tlast
//  cfg     | in        | [15:0] timeout_ticks          | -          | -
//  in      | in        | [7:0] rx_byte                 | [0] cmd    | -
//  out     | out       | [7:0] value, [13:8] byte_index| [2:0] kind | last
//
// One input beat is taken per cycle while the command queue has room and the
// buffer bank being filled is free; a finished packet streams out one byte
// per cycle while out_tready stays high, from a two-bank buffer.
// Reset (rst_n, synchronous) returns to idle with timeout_ticks at 100.
// Output stalls back up through the read stage into the queue and then to
// in_tready; cfg_tready is always high.
module handshake_packet_receiver_unit #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [15:0] cfg_tdata,   // [15:0] timeout_ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic [0:0]  in_tuser,    // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] value, [13:8] byte_index, [15:14] zero
  output logic [2:0]  out_tuser,   // [2:0] kind
  output logic        out_tlast
);

  localparam int PACKET_BYTES = 2 + PAYLOAD_BYTES;

  logic               q_full;
  logic               q_push;
  hpr_pkg::cmd_t      q_push_cmd;
  logic               q_pop;
  hpr_pkg::cmd_t      q_pop_cmd;
  logic               q_valid;
  hpr_pkg::buf_wr_t   buf_wr;
  hpr_pkg::bank_rel_t bank_rel;
  hpr_pkg::kind_t     out_kind;
  logic [7:0]         out_value;
  logic [5:0]         out_idx;

  assign cfg_tready = 1'b1;

  hpr_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_tvalid),
    .cfg_data (cfg_tdata),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser[0]),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd),
    .buf_wr   (buf_wr),
    .bank_rel (bank_rel)
  );

  hpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_pop_cmd),
    .not_empty (q_valid)
  );

  hpr_back #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .buf_wr    (buf_wr),
    .bank_rel  (bank_rel),
    .q_valid   (q_valid),
    .q_cmd     (q_pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_idx   (out_idx),
    .out_last  (out_tlast)
  );

  // Pack result beat
  assign out_tdata = {2'b00, out_idx, out_value};
  assign out_tuser = out_kind;

endmodule
